/* rtl/clipped_sprite_span_blit_assert.svh */
// Assertion macros for the span blitter modules; only csb_seq includes them.
// Each macro expects the clock aclk in scope; CSB_ASSERT also expects the active-low reset aresetn.
`ifndef CLIPPED_SPRITE_SPAN_BLIT_ASSERT_SVH
`define CLIPPED_SPRITE_SPAN_BLIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CSB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CSB_ASSERT(lbl, prop, msg)
`define CSB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/csb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package csb_pkg;

    localparam int SCREEN_ADDR_BITS_DEF = 24;
    localparam int SOURCE_ADDR_BITS_DEF = 20;
    localparam int MAX_SPRITE_WIDTH     = 256;
    localparam int MAX_SPRITE_HEIGHT    = 64;

    localparam int CLIP_W   = 12;
    localparam int PITCH_W  = 13;
    localparam int SPAN_W   = 9;
    localparam int HEIGHT_W = 7;
    localparam int COORD_W  = 13;
    localparam int BASE_W   = 20;
    localparam int ROW_W    = $clog2(MAX_SPRITE_HEIGHT + 1);
    localparam int MUL_W    = 13;
    localparam int IN_W     = ((2 * COORD_W + BASE_W + 7) / 8) * 8;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [CLIP_W-1:0]   CLIP_LEFT_RST     = CLIP_W'(0);
    localparam logic [CLIP_W-1:0]   CLIP_RIGHT_RST    = CLIP_W'(640);
    localparam logic [CLIP_W-1:0]   CLIP_TOP_RST      = CLIP_W'(0);
    localparam logic [CLIP_W-1:0]   CLIP_BOTTOM_RST   = CLIP_W'(480);
    localparam logic [PITCH_W-1:0]  LINE_PITCH_RST    = PITCH_W'(640);
    localparam logic [SPAN_W-1:0]   SPRITE_WIDTH_RST  = SPAN_W'(32);
    localparam logic [HEIGHT_W-1:0] SPRITE_HEIGHT_RST = HEIGHT_W'(32);

    typedef enum logic [2:0] {
        REG_CLIP_LEFT     = 3'd0,
        REG_CLIP_RIGHT    = 3'd1,
        REG_CLIP_TOP      = 3'd2,
        REG_CLIP_BOTTOM   = 3'd3,
        REG_LINE_PITCH    = 3'd4,
        REG_SPRITE_WIDTH  = 3'd5,
        REG_SPRITE_HEIGHT = 3'd6
    } csb_reg_t;

    typedef struct packed {
        logic [CLIP_W-1:0]   clip_left;
        logic [CLIP_W-1:0]   clip_right;
        logic [CLIP_W-1:0]   clip_top;
        logic [CLIP_W-1:0]   clip_bottom;
        logic [PITCH_W-1:0]  line_pitch;
        logic [SPAN_W-1:0]   sprite_width;
        logic [HEIGHT_W-1:0] sprite_height;
    } csb_cfg_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_MAX,
        ALU_MIN
    } csb_alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NX,
        ST_NY,
        ST_EX0,
        ST_EX,
        ST_CW,
        ST_EY0,
        ST_EY,
        ST_NYS,
        ST_DM,
        ST_DA,
        ST_RX,
        ST_SA,
        ST_RY,
        ST_RM,
        ST_SB,
        ST_LOAD,
        ST_STEP_S
    } csb_state_t;

endpackage
`default_nettype wire

/* rtl/clipped_sprite_span_blit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A request is accepted only while the sequencer is idle; it then clips the sprite, works out the
// start addresses and emits one span per visible row, in the states ST_NX through ST_SB and then
// ST_LOAD and ST_STEP_S, which step the destination and source addresses in turn on the single
// shared ALU. A fully clipped request emits no span and returns to idle after ST_NYS.
// Reset is synchronous and active low: it empties the block and restores the register defaults.
module clipped_sprite_span_blit
    import csb_pkg::*;
#(
    parameter int SCREEN_ADDR_BITS = SCREEN_ADDR_BITS_DEF,
    parameter int SOURCE_ADDR_BITS = SOURCE_ADDR_BITS_DEF,
    localparam int OUT_W = ((SCREEN_ADDR_BITS + SOURCE_ADDR_BITS + SPAN_W + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // sprite_x, sprite_y, source_base
    input  wire logic [IN_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // dest_address, source_address, span_length
    output logic [OUT_W-1:0]        m_axis_tdata,
    output logic                    m_axis_tlast
);

    localparam int ALU_W = ((SCREEN_ADDR_BITS > SOURCE_ADDR_BITS)
                            ? SCREEN_ADDR_BITS : SOURCE_ADDR_BITS) + 2;

    csb_cfg_t                    cfg;
    csb_alu_op_t                 alu_op;
    logic signed [ALU_W-1:0]     alu_a;
    logic signed [ALU_W-1:0]     alu_b;
    logic signed [ALU_W-1:0]     alu_y;
    logic [SCREEN_ADDR_BITS-1:0] dest;
    logic [SOURCE_ADDR_BITS-1:0] source;
    logic [SPAN_W-1:0]           length;

    assign m_axis_tdata = OUT_W'({length, source, dest});

    csb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csb_alu #(
        .ALU_W (ALU_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    csb_seq #(
        .SCREEN_ADDR_BITS (SCREEN_ADDR_BITS),
        .SOURCE_ADDR_BITS (SOURCE_ADDR_BITS),
        .ALU_W            (ALU_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_x      (s_axis_tdata[COORD_W-1:0]),
        .s_y      (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .s_base   (s_axis_tdata[2*COORD_W+BASE_W-1:2*COORD_W]),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_dest   (dest),
        .m_source (source),
        .m_length (length),
        .m_last   (m_axis_tlast),
        .alu_op   (alu_op),
        .alu_a    (alu_a),
        .alu_b    (alu_b),
        .alu_y    (alu_y)
    );

endmodule
`default_nettype wire

/* rtl/csb_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module csb_cfg
    import csb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output csb_cfg_t                cfg
);

    csb_cfg_t cfg_reg;
    csb_cfg_t cfg_next;
    csb_reg_t sel;

    assign sel    = csb_reg_t'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_left     <= CLIP_LEFT_RST;
            cfg_reg.clip_right    <= CLIP_RIGHT_RST;
            cfg_reg.clip_top      <= CLIP_TOP_RST;
            cfg_reg.clip_bottom   <= CLIP_BOTTOM_RST;
            cfg_reg.line_pitch    <= LINE_PITCH_RST;
            cfg_reg.sprite_width  <= SPRITE_WIDTH_RST;
            cfg_reg.sprite_height <= SPRITE_HEIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (sel)
                REG_CLIP_LEFT:     cfg_next.clip_left     = pwdata[CLIP_W-1:0];
                REG_CLIP_RIGHT:    cfg_next.clip_right    = pwdata[CLIP_W-1:0];
                REG_CLIP_TOP:      cfg_next.clip_top      = pwdata[CLIP_W-1:0];
                REG_CLIP_BOTTOM:   cfg_next.clip_bottom   = pwdata[CLIP_W-1:0];
                REG_LINE_PITCH:    cfg_next.line_pitch    = pwdata[PITCH_W-1:0];
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = pwdata[SPAN_W-1:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = pwdata[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_CLIP_LEFT:     prdata = PDATA_W'(cfg_reg.clip_left);
            REG_CLIP_RIGHT:    prdata = PDATA_W'(cfg_reg.clip_right);
            REG_CLIP_TOP:      prdata = PDATA_W'(cfg_reg.clip_top);
            REG_CLIP_BOTTOM:   prdata = PDATA_W'(cfg_reg.clip_bottom);
            REG_LINE_PITCH:    prdata = PDATA_W'(cfg_reg.line_pitch);
            REG_SPRITE_WIDTH:  prdata = PDATA_W'(cfg_reg.sprite_width);
            REG_SPRITE_HEIGHT: prdata = PDATA_W'(cfg_reg.sprite_height);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/csb_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
module csb_alu
    import csb_pkg::*;
#(
    parameter int ALU_W = 26
) (
    input  wire csb_alu_op_t        op,
    input  wire logic signed [ALU_W-1:0] a,
    input  wire logic signed [ALU_W-1:0] b,
    output logic signed [ALU_W-1:0]      y
);

    logic [2*MUL_W-1:0] prod;
    logic               a_gt_b;

    assign prod   = a[MUL_W-1:0] * b[MUL_W-1:0];
    assign a_gt_b = (a > b);

    always_comb begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            ALU_MUL: y = ALU_W'(prod);
            ALU_MAX: y = a_gt_b ? a : b;
            ALU_MIN: y = a_gt_b ? b : a;
            default: y = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/csb_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_sprite_span_blit_assert.svh"
module csb_seq
    import csb_pkg::*;
#(
    parameter int SCREEN_ADDR_BITS = SCREEN_ADDR_BITS_DEF,
    parameter int SOURCE_ADDR_BITS = SOURCE_ADDR_BITS_DEF,
    parameter int ALU_W            = 26
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire csb_cfg_t                    cfg,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [COORD_W-1:0]          s_x,
    input  wire logic [COORD_W-1:0]          s_y,
    input  wire logic [BASE_W-1:0]           s_base,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [SCREEN_ADDR_BITS-1:0]      m_dest,
    output logic [SOURCE_ADDR_BITS-1:0]      m_source,
    output logic [SPAN_W-1:0]                m_length,
    output logic                             m_last,
    output csb_alu_op_t                      alu_op,
    output logic signed [ALU_W-1:0]          alu_a,
    output logic signed [ALU_W-1:0]          alu_b,
    input  wire logic signed [ALU_W-1:0]     alu_y
);

    csb_state_t                  state_reg, state_next;
    logic [COORD_W-1:0]          x_reg, x_next;
    logic [COORD_W-1:0]          y_reg, y_next;
    logic [BASE_W-1:0]           base_reg, base_next;
    logic [CLIP_W-1:0]           nx_reg, nx_next;
    logic [CLIP_W-1:0]           ny_reg, ny_next;
    logic signed [ALU_W-1:0]     tmp_reg, tmp_next;
    logic [SPAN_W-1:0]           cw_reg, cw_next;
    logic                        cw_ok_reg, cw_ok_next;
    logic [ROW_W-1:0]            rows_reg, rows_next;
    logic [SCREEN_ADDR_BITS-1:0] dest_row_reg, dest_row_next;
    logic [SOURCE_ADDR_BITS-1:0] src_row_reg, src_row_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SCREEN_ADDR_BITS-1:0] out_dest_reg, out_dest_next;
    logic [SOURCE_ADDR_BITS-1:0] out_src_reg, out_src_next;
    logic [SPAN_W-1:0]           out_len_reg, out_len_next;
    logic                        out_last_reg, out_last_next;

    logic signed [ALU_W-1:0]     x_ext, y_ext;
    logic [SPAN_W-1:0]           w_eff;
    logic [HEIGHT_W-1:0]         h_eff;
    logic                        alu_pos;

    assign x_ext = {{(ALU_W-COORD_W){x_reg[COORD_W-1]}}, x_reg};
    assign y_ext = {{(ALU_W-COORD_W){y_reg[COORD_W-1]}}, y_reg};
    assign w_eff = (cfg.sprite_width > SPAN_W'(MAX_SPRITE_WIDTH))
                   ? SPAN_W'(MAX_SPRITE_WIDTH) : cfg.sprite_width;
    assign h_eff = (cfg.sprite_height > HEIGHT_W'(MAX_SPRITE_HEIGHT))
                   ? HEIGHT_W'(MAX_SPRITE_HEIGHT) : cfg.sprite_height;
    assign alu_pos = !alu_y[ALU_W-1] && (alu_y != '0);

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_dest   = out_dest_reg;
    assign m_source = out_src_reg;
    assign m_length = out_len_reg;
    assign m_last   = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_reg      <= '0;
            cw_reg        <= '0;
            cw_ok_reg     <= 1'b0;
            dest_row_reg  <= '0;
            src_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cw_reg        <= cw_next;
            cw_ok_reg     <= cw_ok_next;
            dest_row_reg  <= dest_row_next;
            src_row_reg   <= src_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        base_reg     <= base_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        tmp_reg      <= tmp_next;
        out_dest_reg <= out_dest_next;
        out_src_reg  <= out_src_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        base_next      = base_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        tmp_next       = tmp_reg;
        cw_next        = cw_reg;
        cw_ok_next     = cw_ok_reg;
        rows_next      = rows_reg;
        dest_row_next  = dest_row_reg;
        src_row_next   = src_row_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_dest_next  = out_dest_reg;
        out_src_next   = out_src_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_x;
                    y_next     = s_y;
                    base_next  = s_base;
                    state_next = ST_NX;
                end
            end
            ST_NX: begin
                alu_op     = ALU_MAX;
                alu_a      = x_ext;
                alu_b      = ALU_W'(cfg.clip_left);
                nx_next    = alu_y[CLIP_W-1:0];
                state_next = ST_NY;
            end
            ST_NY: begin
                alu_op     = ALU_MAX;
                alu_a      = y_ext;
                alu_b      = ALU_W'(cfg.clip_top);
                ny_next    = alu_y[CLIP_W-1:0];
                state_next = ST_EX0;
            end
            ST_EX0: begin
                alu_op     = ALU_ADD;
                alu_a      = x_ext;
                alu_b      = ALU_W'(w_eff);
                tmp_next   = alu_y;
                state_next = ST_EX;
            end
            ST_EX: begin
                alu_op     = ALU_MIN;
                alu_a      = tmp_reg;
                alu_b      = ALU_W'(cfg.clip_right);
                tmp_next   = alu_y;
                state_next = ST_CW;
            end
            ST_CW: begin
                alu_op     = ALU_SUB;
                alu_a      = tmp_reg;
                alu_b      = ALU_W'(nx_reg);
                cw_next    = alu_y[SPAN_W-1:0];
                cw_ok_next = alu_pos;
                state_next = ST_EY0;
            end
            ST_EY0: begin
                alu_op     = ALU_ADD;
                alu_a      = y_ext;
                alu_b      = ALU_W'(h_eff);
                tmp_next   = alu_y;
                state_next = ST_EY;
            end
            ST_EY: begin
                alu_op     = ALU_MIN;
                alu_a      = tmp_reg;
                alu_b      = ALU_W'(cfg.clip_bottom);
                tmp_next   = alu_y;
                state_next = ST_NYS;
            end
            ST_NYS: begin
                alu_op = ALU_SUB;
                alu_a  = tmp_reg;
                alu_b  = ALU_W'(ny_reg);
                if (cw_ok_reg && alu_pos) begin
                    rows_next  = alu_y[ROW_W-1:0];
                    state_next = ST_DM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DM: begin
                alu_op     = ALU_MUL;
                alu_a      = ALU_W'(ny_reg);
                alu_b      = ALU_W'(cfg.line_pitch);
                tmp_next   = alu_y;
                state_next = ST_DA;
            end
            ST_DA: begin
                alu_op        = ALU_ADD;
                alu_a         = tmp_reg;
                alu_b         = ALU_W'(nx_reg);
                dest_row_next = alu_y[SCREEN_ADDR_BITS-1:0];
                state_next    = ST_RX;
            end
            ST_RX: begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(nx_reg);
                alu_b      = x_ext;
                tmp_next   = alu_y;
                state_next = ST_SA;
            end
            ST_SA: begin
                alu_op       = ALU_ADD;
                alu_a        = tmp_reg;
                alu_b        = ALU_W'(base_reg);
                src_row_next = alu_y[SOURCE_ADDR_BITS-1:0];
                state_next   = ST_RY;
            end
            ST_RY: begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(ny_reg);
                alu_b      = y_ext;
                tmp_next   = alu_y;
                state_next = ST_RM;
            end
            ST_RM: begin
                alu_op     = ALU_MUL;
                alu_a      = tmp_reg;
                alu_b      = ALU_W'(w_eff);
                tmp_next   = alu_y;
                state_next = ST_SB;
            end
            ST_SB: begin
                alu_op       = ALU_ADD;
                alu_a        = ALU_W'(src_row_reg);
                alu_b        = tmp_reg;
                src_row_next = alu_y[SOURCE_ADDR_BITS-1:0];
                state_next   = ST_LOAD;
            end
            ST_LOAD: begin
                // The destination step shares this cycle with the hand-over to the
                // output register.
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(dest_row_reg);
                alu_b  = ALU_W'(cfg.line_pitch);
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_dest_next  = dest_row_reg;
                    out_src_next   = src_row_reg;
                    out_len_next   = cw_reg;
                    out_last_next  = (rows_reg == ROW_W'(1));
                    rows_next      = rows_reg - ROW_W'(1);
                    dest_row_next  = alu_y[SCREEN_ADDR_BITS-1:0];
                    state_next     = (rows_reg == ROW_W'(1)) ? ST_IDLE : ST_STEP_S;
                end
            end
            ST_STEP_S: begin
                alu_op       = ALU_ADD;
                alu_a        = ALU_W'(src_row_reg);
                alu_b        = ALU_W'(w_eff);
                src_row_next = alu_y[SOURCE_ADDR_BITS-1:0];
                state_next   = ST_LOAD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CSB_ASSERT(a_idle_no_rows, (state_reg == ST_IDLE) |-> (rows_reg == '0), "rows pending while idle")
    `CSB_ASSERT(a_load_has_rows, (state_reg == ST_LOAD) |-> (rows_reg != '0), "load with no rows left")
    `CSB_ASSERT(a_span_nonzero, out_valid_reg |-> (out_len_reg != '0), "empty span presented")
    `CSB_ASSERT(a_last_ends_walk, (state_reg == ST_LOAD && state_next == ST_IDLE) |-> out_last_next, "walk ended without last span")

endmodule
`default_nettype wire
